@@ sv/c3fm_pkg.sv @@
// ----------------------------------------------------------------------------
// c3fm_pkg
// Shared types and constants of the 3x3 convolution core with frame maximum:
// register indexes, fixed field widths and the structs that carry an item's
// position and flags down the pipeline and into the output queue.
// ----------------------------------------------------------------------------
package c3fm_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_KERNEL_TOP   = 3'd2,
        CFG_KERNEL_MID   = 3'd3,
        CFG_KERNEL_BOT   = 3'd4
    } t_cfg_idx;

    // Frame geometry.
    localparam int DIM_W      = 11;      // width of the frame size registers
    localparam int ROW_W      = 10;      // row counter
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 3;

    // Kernel coefficients: three signed Q1.14 values per register.
    localparam int KROW_W    = 48;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 14;

    // Result fields.
    localparam int RES_W  = 24;
    localparam int POS_W  = 10;
    localparam int FMAX_W = 23;
    localparam int RES_MAX = 8388607;
    localparam int RES_MIN = -8388608;

    // Output queue.
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = 4;

    // Position and flags that travel with each pixel.
    typedef struct packed {
        logic             emit;   // interior position: a result is produced
        logic             last;   // final interior result of the frame
        logic             wrap;   // frame ends after this pixel
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } t_tag;

    // One queued result.
    typedef struct packed {
        logic [RES_W-1:0]  result;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic [FMAX_W-1:0] fmax;
        logic              last;
    } t_res;

endpackage

@@ sv/c3fm_mac.sv @@
// ----------------------------------------------------------------------------
// c3fm_mac
// Pipelined 3x3 multiply-accumulate: nine products, row sums, total, then an
// arithmetic shift to Q.8 and saturation to 24 bits, each step registered;
// one window per clock.
// ----------------------------------------------------------------------------
module c3fm_mac #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  c3fm_pkg::t_tag                        i_tag,
    input  logic signed [PIXEL_BITS-1:0]          i_win [9],
    input  logic [c3fm_pkg::KROW_W-1:0]           i_krow [3],
    output logic                                  o_valid,
    output c3fm_pkg::t_tag                        o_tag,
    output logic signed [c3fm_pkg::RES_W-1:0]     o_q
);
    import c3fm_pkg::*;

    localparam int PROD_W = PIXEL_BITS + COEF_W;
    localparam int RS_W   = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;
    localparam int LAT    = 4;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(RES_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(RES_MIN);

    logic signed [PROD_W-1:0] prod_c [9];
    logic signed [PROD_W-1:0] r_prod [9];
    logic signed [RS_W-1:0]   r_rsum [3];
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  sum_sh;
    logic signed [RES_W-1:0]  q_c;
    logic signed [RES_W-1:0]  r_q;
    logic [LAT-1:0]           r_v;
    t_tag                     r_tag [LAT];

    // Products: window row dy pairs with kernel row 2-dy, column dx with
    // coefficient slot 2-dx, which gives the true (flipped) convolution.
    always_comb begin
        for (int dy = 0; dy < 3; dy++) begin
            for (int dx = 0; dx < 3; dx++) begin
                prod_c[dy*3+dx] = PROD_W'(i_win[dy*3+dx]) *
                    PROD_W'($signed(i_krow[2-dy][(2-dx)*COEF_W +: COEF_W]));
            end
        end
    end

    // Shift down to Q.8 (floor) and saturate.
    always_comb begin
        sum_sh = r_sum >>> COEF_FRAC;
        if (sum_sh > SAT_HI) begin
            q_c = SAT_HI[RES_W-1:0];
        end else if (sum_sh < SAT_LO) begin
            q_c = SAT_LO[RES_W-1:0];
        end else begin
            q_c = sum_sh[RES_W-1:0];
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_prod[k] <= prod_c[k];
        end
        for (int d = 0; d < 3; d++) begin
            r_rsum[d] <= RS_W'(r_prod[d*3]) + RS_W'(r_prod[d*3+1]) +
                         RS_W'(r_prod[d*3+2]);
        end
        r_sum <= SUM_W'(r_rsum[0]) + SUM_W'(r_rsum[1]) + SUM_W'(r_rsum[2]);
        r_q   <= q_c;
        r_tag[0] <= i_tag;
        for (int s = 1; s < LAT; s++) begin
            r_tag[s] <= r_tag[s-1];
        end
    end

    // Valid bits along the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_v[LAT-1];
    assign o_tag   = r_tag[LAT-1];
    assign o_q     = r_q;

endmodule

@@ sv/conv3x3_with_frame_max_core.sv @@
// ----------------------------------------------------------------------------
// conv3x3_with_frame_max_core
// Streams a frame of signed Q8.8 pixels in raster order, keeps the two rows
// above in a line memory and emits the 3x3 convolution of every interior
// position with its position, the running frame maximum and a last flag.
//
//   Channel  | Direction | Handshake            | Beat
//   ---------+-----------+----------------------+----------------------------
//   pixel in | input     | i_valid / o_stall    | i_pixel
//   result   | output    | o_valid / i_stall    | o_result, o_out_col,
//            |           |                      | o_out_row, o_frame_max, o_last
//   config   | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel is accepted per clock while o_stall is low. The line memory is read
// on the accept cycle and written back in the following cycle; the same entry
// is reused only every frame_width pixels, so no forwarding is needed.
// A result passes stage 1, the window and the multiply-accumulate stages and
// waits in a 16-beat output queue. o_stall rises only when 16 results are pending.
// Reset (synchronous) clears counters, window, maximum and configuration;
// the line memory is not cleared and is first read in rows that emit nothing.
// ----------------------------------------------------------------------------
module conv3x3_with_frame_max_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Pixel input
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [PIXEL_BITS-1:0]           i_pixel,
    // Result output
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [c3fm_pkg::RES_W-1:0]      o_result,
    output logic [c3fm_pkg::POS_W-1:0]             o_out_col,
    output logic [c3fm_pkg::POS_W-1:0]             o_out_row,
    output logic [c3fm_pkg::FMAX_W-1:0]            o_frame_max,
    output logic                                   o_last,
    // Configuration
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [c3fm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [c3fm_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import c3fm_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int LIM_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int LN_W  = 2 * PIXEL_BITS;
    localparam int CNT_W = FIFO_AW + 1;

    // Configuration registers.
    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;
    logic [KROW_W-1:0] r_krow [3];

    // Position counters and stage-0 decode.
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [LIM_W-1:0]  w_lim;
    logic [LIM_W-1:0]  fw_x;
    logic [LIM_W-1:0]  c_x;
    logic [LIM_W-1:0]  c_inc;
    logic [LIM_W-1:0]  c_m1;
    logic [DIM_W-1:0]  h_lim;
    logic [DIM_W-1:0]  r_x;
    logic [DIM_W-1:0]  r_inc;
    logic [DIM_W-1:0]  r_m1;
    logic              col_wrap;
    logic              row_wrap;
    logic              accept;
    t_tag              tag0;

    // Line memory: upper half is the row above, lower half two rows above.
    logic [LN_W-1:0]   r_line [MAX_WIDTH];
    logic [LN_W-1:0]   r_rd;

    // Stage 1 and window.
    logic                         r_s1_valid;
    t_tag                         r_s1_tag;
    logic signed [PIXEL_BITS-1:0] r_s1_pix;
    logic [COL_W-1:0]             r_s1_addr;
    logic                         r_w_valid;
    t_tag                         r_w_tag;
    logic signed [PIXEL_BITS-1:0] r_win [9];

    // Final stage and queue.
    logic                         fin_valid;
    t_tag                         fin_tag;
    logic signed [RES_W-1:0]      fin_q;
    logic [FMAX_W-1:0]            r_max;
    logic [FMAX_W-1:0]            cand_max;
    logic                         push;
    logic                         pop;
    t_res                         r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]           r_wr_ptr;
    logic [FIFO_AW-1:0]           r_rd_ptr;
    logic [CNT_W-1:0]             r_cnt;
    logic [CNT_W-1:0]             r_pend;

    // Configuration writes; indexes beyond the list are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(MIN_DIM);
            r_frame_height <= DIM_W'(MIN_DIM);
            for (int k = 0; k < 3; k++) begin
                r_krow[k] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                CFG_KERNEL_TOP:   r_krow[0]      <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_MID:   r_krow[1]      <= i_cfg_data[KROW_W-1:0];
                CFG_KERNEL_BOT:   r_krow[2]      <= i_cfg_data[KROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped frame size and the decode of the current position.
    always_comb begin
        fw_x = LIM_W'(r_frame_width);
        if (fw_x < LIM_W'(MIN_DIM)) begin
            w_lim = LIM_W'(MIN_DIM);
        end else if (fw_x > LIM_W'(MAX_WIDTH)) begin
            w_lim = LIM_W'(MAX_WIDTH);
        end else begin
            w_lim = fw_x;
        end
        if (r_frame_height < DIM_W'(MIN_DIM)) begin
            h_lim = DIM_W'(MIN_DIM);
        end else if (r_frame_height > DIM_W'(MAX_HEIGHT)) begin
            h_lim = DIM_W'(MAX_HEIGHT);
        end else begin
            h_lim = r_frame_height;
        end

        c_x   = LIM_W'(r_col);
        c_inc = c_x + LIM_W'(1);
        c_m1  = c_x - LIM_W'(1);
        r_x   = DIM_W'(r_row);
        r_inc = r_x + DIM_W'(1);
        r_m1  = r_x - DIM_W'(1);

        col_wrap = (c_inc >= w_lim);
        row_wrap = (r_inc >= h_lim);

        tag0.emit = (c_x >= LIM_W'(2)) && (r_x >= DIM_W'(2)) &&
                    (c_x < w_lim) && (r_x < h_lim);
        tag0.last = (c_x == w_lim - LIM_W'(1)) && (r_x == h_lim - DIM_W'(1));
        tag0.wrap = col_wrap && row_wrap;
        tag0.col  = c_m1[POS_W-1:0];
        tag0.row  = r_m1[POS_W-1:0];

        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : r_inc[ROW_W-1:0];
        end else begin
            n_col = c_inc[COL_W-1:0];
            n_row = r_row;
        end
    end

    assign accept = i_valid && !o_stall;

    // Position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line memory: read on accept, write back the shifted pair in the following cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_line[r_col];
        end
        if (r_s1_valid) begin
            r_line[r_s1_addr] <= {r_s1_pix, r_rd[LN_W-1:PIXEL_BITS]};
        end
    end

    // Stage 1 payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_tag  <= tag0;
            r_s1_pix  <= i_pixel;
            r_s1_addr <= r_col;
        end
        if (r_s1_valid) begin
            r_w_tag <= r_s1_tag;
        end
    end

    // Stage 1 control and the 3x3 window shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_w_valid  <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_s1_valid <= accept;
            r_w_valid  <= r_s1_valid;
            if (r_s1_valid) begin
                for (int dy = 0; dy < 3; dy++) begin
                    r_win[dy*3]   <= r_win[dy*3+1];
                    r_win[dy*3+1] <= r_win[dy*3+2];
                end
                r_win[2] <= $signed(r_rd[PIXEL_BITS-1:0]);
                r_win[5] <= $signed(r_rd[LN_W-1:PIXEL_BITS]);
                r_win[8] <= r_s1_pix;
            end
        end
    end

    // Multiply-accumulate pipeline.
    c3fm_mac #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_w_valid),
        .i_tag   (r_w_tag),
        .i_win   (r_win),
        .i_krow  (r_krow),
        .o_valid (fin_valid),
        .o_tag   (fin_tag),
        .o_q     (fin_q)
    );

    // Running maximum including the current result.
    always_comb begin
        if (fin_tag.emit && !fin_q[RES_W-1] && (fin_q[FMAX_W-1:0] > r_max)) begin
            cand_max = fin_q[FMAX_W-1:0];
        end else begin
            cand_max = r_max;
        end
    end

    assign push = fin_valid && fin_tag.emit;
    assign pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (fin_valid) begin
            r_max <= fin_tag.wrap ? '0 : cand_max;
        end
    end

    // Output queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= '{result: fin_q, col: fin_tag.col, row: fin_tag.row,
                                  fmax: cand_max, last: fin_tag.last};
        end
    end

    // Queue pointers, fill and the count of results still owed downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_pend   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_cnt  <= r_cnt + CNT_W'(push) - CNT_W'(pop);
            r_pend <= r_pend + CNT_W'(accept && tag0.emit) - CNT_W'(pop);
        end
    end

    assign o_stall     = (r_pend == CNT_W'(FIFO_DEPTH));
    assign o_valid     = (r_cnt != '0);
    assign o_result    = r_fifo[r_rd_ptr].result;
    assign o_out_col   = r_fifo[r_rd_ptr].col;
    assign o_out_row   = r_fifo[r_rd_ptr].row;
    assign o_frame_max = r_fifo[r_rd_ptr].fmax;
    assign o_last      = r_fifo[r_rd_ptr].last;

    // The read of a new pixel's entry never meets the write-back of the same entry.
    a_line_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_s1_valid |-> r_col != r_s1_addr)
        else $error("line memory read and write hit the same entry");

    // Every queued result is counted as pending, so the queue cannot overflow.
    a_queue_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_pend)
        else $error("output queue holds more than the pending count");

    // The last result of a frame is the pixel that ends the frame.
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && fin_tag.last |-> fin_tag.wrap)
        else $error("last result does not close the frame");

    // The maximum starts again from zero after a frame.
    a_max_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_valid && fin_tag.wrap |=> r_max == '0)
        else $error("frame maximum not cleared at end of frame");

endmodule
